[rtl/core/dfla_pkg.sv]
// Package for the descriptor free-list allocator: sizes, register indexes, codes,
// the controller state type and the structs between the queue and the control logic.
// No dependencies.
package dfla_pkg;

    // Queue depth and the widths that follow from it.
    localparam int SLOT_DEPTH = 1024;
    localparam int PTR_W      = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
    localparam int CNT_W      = $clog2(SLOT_DEPTH + 1);
    localparam int PUSH_W     = PTR_W + 1;

    // Fixed field widths.
    localparam int INDEX_W    = 10;
    localparam int ADDR_W     = 48;
    localparam int STRIDE_W   = 11;
    localparam int CAP_W      = 11;
    localparam int TYPE_W     = 2;
    localparam int ID_W       = 8;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 11;
    localparam int PROD_W     = INDEX_W + STRIDE_W;
    localparam int CFG_IDX_W  = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CPU_BASE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GPU_BASE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HEAP_TYPE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HEAP_ID   = 3'd5;

    // Reset values.
    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 11'd32;
    localparam logic [CAP_W-1:0]    CAP_RESET    = 11'd1024;
    localparam int CAP_EFF_RESET_I = (1024 > SLOT_DEPTH) ? SLOT_DEPTH : 1024;
    localparam logic [CNT_W-1:0] CAP_EFF_RESET = CNT_W'(CAP_EFF_RESET_I);
    localparam logic [PTR_W-1:0] WPTR_RESET    = PTR_W'(CAP_EFF_RESET_I % SLOT_DEPTH);

    // Operation codes.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY       = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_WRONG_OWNER = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL        = 2'd3;

    // Heap types that are shader visible.
    localparam logic [TYPE_W-1:0] HEAP_SHADER_RESOURCE = 2'd0;
    localparam logic [TYPE_W-1:0] HEAP_SAMPLER         = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_ADD
    } state_t;

    typedef struct packed {
        logic               refill;
        logic [CNT_W-1:0]   refill_cap;
        logic               rd_en;
        logic               pop;
        logic               push;
        logic [INDEX_W-1:0] push_index;
    } queue_cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0]   free_total;
        logic [CNT_W-1:0]   alloc_total;
        logic [INDEX_W-1:0] head_index;
    } queue_stat_t;

    // Capacity register value clamped to the queue depth.
    function automatic logic [CNT_W-1:0] clamp_cap(input logic [CAP_W-1:0] cap);
        if (int'(cap) > SLOT_DEPTH) begin
            return CNT_W'(SLOT_DEPTH);
        end
        return CNT_W'(cap);
    endfunction

endpackage

[rtl/core/dfla_queue.sv]
// Free-index queue: the slot memory, its read and write pointers and the counters.
// Depends on dfla_pkg.
module dfla_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [dfla_pkg::CNT_W-1:0]  cap_eff,
    input  dfla_pkg::queue_cmd_t        cmd,
    output dfla_pkg::queue_stat_t       stat
);

    logic [dfla_pkg::INDEX_W-1:0] mem [dfla_pkg::SLOT_DEPTH];
    logic [dfla_pkg::INDEX_W-1:0] mem_q;

    logic [dfla_pkg::PTR_W-1:0]  rp_reg, rp_next;
    logic [dfla_pkg::PTR_W-1:0]  wp_reg, wp_next;
    logic [dfla_pkg::CNT_W-1:0]  free_reg, free_next;
    logic [dfla_pkg::CNT_W-1:0]  alloc_reg, alloc_next;
    logic [dfla_pkg::PUSH_W-1:0] push_cnt_reg, push_cnt_next;
    logic                        fresh_reg, fresh_next;
    logic [dfla_pkg::PTR_W-1:0]  pos_reg;
    logic [dfla_pkg::PUSH_W:0]   thresh;

    function automatic logic [dfla_pkg::PTR_W-1:0] advance(
        input logic [dfla_pkg::PTR_W-1:0] p
    );
        if (int'(p) == dfla_pkg::SLOT_DEPTH - 1) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    // An entry below the capacity that no push has reached since the last refill
    // still holds its own position. Push k lands at (capacity + k) mod depth, so
    // position p below the capacity is overwritten by push p + depth - capacity.
    always_comb
    begin
        thresh = (dfla_pkg::PUSH_W + 1)'(rp_reg)
               + (dfla_pkg::PUSH_W + 1)'(dfla_pkg::SLOT_DEPTH)
               - (dfla_pkg::PUSH_W + 1)'(cap_eff);
        fresh_next = (dfla_pkg::CNT_W'(rp_reg) < cap_eff)
                  && ({1'b0, push_cnt_reg} <= thresh);
    end

    always_comb
    begin
        rp_next       = rp_reg;
        wp_next       = wp_reg;
        free_next     = free_reg;
        alloc_next    = alloc_reg;
        push_cnt_next = push_cnt_reg;
        if (cmd.refill) begin
            rp_next       = '0;
            wp_next       = (int'(cmd.refill_cap) == dfla_pkg::SLOT_DEPTH)
                          ? '0 : dfla_pkg::PTR_W'(cmd.refill_cap);
            free_next     = cmd.refill_cap;
            alloc_next    = '0;
            push_cnt_next = '0;
        end else if (cmd.pop) begin
            rp_next    = advance(rp_reg);
            free_next  = free_reg - 1'b1;
            alloc_next = alloc_reg + 1'b1;
        end else if (cmd.push) begin
            wp_next   = advance(wp_reg);
            free_next = free_reg + 1'b1;
            if (alloc_reg != '0) begin
                alloc_next = alloc_reg - 1'b1;
            end
            if (push_cnt_reg != '1) begin
                push_cnt_next = push_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rp_reg       <= '0;
            wp_reg       <= dfla_pkg::WPTR_RESET;
            free_reg     <= dfla_pkg::CAP_EFF_RESET;
            alloc_reg    <= '0;
            push_cnt_reg <= '0;
            fresh_reg    <= 1'b0;
        end else begin
            rp_reg       <= rp_next;
            wp_reg       <= wp_next;
            free_reg     <= free_next;
            alloc_reg    <= alloc_next;
            push_cnt_reg <= push_cnt_next;
            if (cmd.rd_en) begin
                fresh_reg <= fresh_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push) begin
            mem[wp_reg] <= cmd.push_index;
        end
        if (cmd.rd_en) begin
            mem_q   <= mem[rp_reg];
            pos_reg <= rp_reg;
        end
    end

    assign stat.free_total  = free_reg;
    assign stat.alloc_total = alloc_reg;
    assign stat.head_index  = fresh_reg ? dfla_pkg::INDEX_W'(pos_reg) : mem_q;

endmodule

[rtl/core/dfla_addr.sv]
// Address unit: registered slot-times-stride product, then the base additions.
// Depends on dfla_pkg.
module dfla_addr (
    input  logic                          clk,
    input  logic                          load,
    input  logic [dfla_pkg::INDEX_W-1:0]  slot,
    input  logic [dfla_pkg::STRIDE_W-1:0] stride,
    input  logic [dfla_pkg::ADDR_W-1:0]   cpu_base,
    input  logic [dfla_pkg::ADDR_W-1:0]   gpu_base,
    input  logic                          visible,
    output logic [dfla_pkg::ADDR_W-1:0]   cpu_sum,
    output logic [dfla_pkg::ADDR_W-1:0]   gpu_sum
);

    logic [dfla_pkg::PROD_W-1:0] prod_reg;
    logic [dfla_pkg::ADDR_W-1:0] offset;

    always_ff @(posedge clk)
    begin
        if (load) begin
            prod_reg <= slot * stride;
        end
    end

    // Sums wrap at the address width.
    assign offset  = dfla_pkg::ADDR_W'(prod_reg);
    assign cpu_sum = cpu_base + offset;
    assign gpu_sum = visible ? (gpu_base + offset) : gpu_base;

endmodule

[rtl/core/descriptor_free_list_allocator_top.sv]
// An accepted request item walks READ, CALC and ADD: it reads the free-index memory, then
// multiplies the slot by the stride, then adds the bases into the response register once
// that register is free. No new item is taken until the last one has left ADD.
// Reset: pointers and counters take the full list at the reset capacity at once; the
// memory is not cleared, untouched entries read as their own position.
// A capacity write refills the list in the same cycle, with no clearing pass.
module descriptor_free_list_allocator_top (
    input  logic                            clk,
    input  logic                            rst_n,

    // Request channel
    input  logic                            req_valid,
    output logic                            req_stall,
    input  logic                            operation,
    input  logic [dfla_pkg::INDEX_W-1:0]    free_index,
    input  logic [dfla_pkg::ID_W-1:0]       owner_id,

    // Response channel
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output logic [dfla_pkg::STATUS_W-1:0]   status,
    output logic [dfla_pkg::INDEX_W-1:0]    slot_index,
    output logic [dfla_pkg::ADDR_W-1:0]     cpu_address,
    output logic [dfla_pkg::ADDR_W-1:0]     gpu_address,
    output logic                            shader_visible,
    output logic [dfla_pkg::COUNT_W-1:0]    used_count,
    output logic [dfla_pkg::COUNT_W-1:0]    available_count,

    // Configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dfla_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dfla_pkg::ADDR_W-1:0]     cfg_data
);

    // Configuration registers.
    logic [dfla_pkg::ADDR_W-1:0]   cpu_base_reg;
    logic [dfla_pkg::ADDR_W-1:0]   gpu_base_reg;
    logic [dfla_pkg::STRIDE_W-1:0] stride_reg;
    logic [dfla_pkg::CAP_W-1:0]    capacity_reg;
    logic [dfla_pkg::TYPE_W-1:0]   heap_type_reg;
    logic [dfla_pkg::ID_W-1:0]     heap_id_reg;
    logic [dfla_pkg::CNT_W-1:0]    cap_eff;
    logic                          cfg_write;

    // Controller.
    dfla_pkg::state_t state_reg, state_next;
    logic             accept;
    logic             rsp_load;
    logic             calc_load;

    // Item held while it is worked on.
    logic                         op_reg;
    logic [dfla_pkg::INDEX_W-1:0] idx_reg;
    logic [dfla_pkg::ID_W-1:0]    owner_reg;

    // Results of the decision cycle.
    logic [dfla_pkg::STATUS_W-1:0] status_calc;
    logic [dfla_pkg::STATUS_W-1:0] status_calc_reg;
    logic                          alloc_ok;
    logic                          alloc_ok_reg;
    logic                          free_ok;
    logic                          visible;
    logic                          visible_reg;
    logic [dfla_pkg::INDEX_W-1:0]  slot_calc_reg;

    // Response register.
    logic                          rsp_valid_reg, rsp_valid_next;
    logic [dfla_pkg::STATUS_W-1:0] status_reg;
    logic [dfla_pkg::INDEX_W-1:0]  slot_reg;
    logic [dfla_pkg::ADDR_W-1:0]   cpu_addr_reg;
    logic [dfla_pkg::ADDR_W-1:0]   gpu_addr_reg;
    logic                          visible_out_reg;
    logic [dfla_pkg::COUNT_W-1:0]  used_reg;
    logic [dfla_pkg::COUNT_W-1:0]  avail_reg;

    dfla_pkg::queue_cmd_t  q_cmd;
    dfla_pkg::queue_stat_t q_stat;
    logic [dfla_pkg::ADDR_W-1:0] cpu_sum;
    logic [dfla_pkg::ADDR_W-1:0] gpu_sum;

    // ------------------------------------------------------------------
    // Configuration. Writes are always taken; the user must send them only
    // while the block holds no item, which the block does not enforce. A
    // capacity write refills the queue in the same cycle with the clamped new capacity.
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign cap_eff   = dfla_pkg::clamp_cap(capacity_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cpu_base_reg  <= '0;
            gpu_base_reg  <= '0;
            stride_reg    <= dfla_pkg::STRIDE_RESET;
            capacity_reg  <= dfla_pkg::CAP_RESET;
            heap_type_reg <= dfla_pkg::HEAP_SHADER_RESOURCE;
            heap_id_reg   <= '0;
        end else if (cfg_write) begin
            unique case (cfg_index)
                dfla_pkg::REG_CPU_BASE:  cpu_base_reg  <= cfg_data;
                dfla_pkg::REG_GPU_BASE:  gpu_base_reg  <= cfg_data;
                dfla_pkg::REG_STRIDE:    stride_reg    <= cfg_data[dfla_pkg::STRIDE_W-1:0];
                dfla_pkg::REG_CAPACITY:  capacity_reg  <= cfg_data[dfla_pkg::CAP_W-1:0];
                dfla_pkg::REG_HEAP_TYPE: heap_type_reg <= cfg_data[dfla_pkg::TYPE_W-1:0];
                dfla_pkg::REG_HEAP_ID:   heap_id_reg   <= cfg_data[dfla_pkg::ID_W-1:0];
                default:                 ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Controller. An item walks IDLE -> READ -> CALC -> ADD. READ issues
    // the memory read at the head of the queue. CALC decides the status,
    // moves a pointer, writes a freed index and starts the multiply. ADD
    // waits until the response register is free and loads it. Only one
    // item is in flight, so a push can never race a read of the same entry.
    // ------------------------------------------------------------------
    assign req_stall = (state_reg != dfla_pkg::ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign rsp_load  = (state_reg == dfla_pkg::ST_ADD) && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dfla_pkg::ST_IDLE: if (accept) state_next = dfla_pkg::ST_READ;
            dfla_pkg::ST_READ: state_next = dfla_pkg::ST_CALC;
            dfla_pkg::ST_CALC: state_next = dfla_pkg::ST_ADD;
            dfla_pkg::ST_ADD:  if (rsp_load) state_next = dfla_pkg::ST_IDLE;
        endcase
    end

    // Decision for the item in the CALC cycle. For a free, a foreign owner
    // is checked before a full list.
    always_comb
    begin
        visible     = (heap_type_reg == dfla_pkg::HEAP_SHADER_RESOURCE)
                   || (heap_type_reg == dfla_pkg::HEAP_SAMPLER);
        status_calc = dfla_pkg::STATUS_OK;
        alloc_ok    = 1'b0;
        free_ok     = 1'b0;
        if (op_reg == dfla_pkg::OP_ALLOC) begin
            if (q_stat.free_total == '0) begin
                status_calc = dfla_pkg::STATUS_EMPTY;
            end else begin
                alloc_ok = 1'b1;
            end
        end else begin
            if (owner_reg != heap_id_reg) begin
                status_calc = dfla_pkg::STATUS_WRONG_OWNER;
            end else if (q_stat.free_total >= cap_eff) begin
                status_calc = dfla_pkg::STATUS_FULL;
            end else begin
                free_ok = 1'b1;
            end
        end
    end

    // Controller outputs.
    always_comb
    begin
        calc_load        = (state_reg == dfla_pkg::ST_CALC);
        q_cmd.refill     = cfg_write && (cfg_index == dfla_pkg::REG_CAPACITY);
        q_cmd.refill_cap = dfla_pkg::clamp_cap(cfg_data[dfla_pkg::CAP_W-1:0]);
        q_cmd.rd_en      = (state_reg == dfla_pkg::ST_READ);
        q_cmd.pop        = calc_load && alloc_ok;
        q_cmd.push       = calc_load && free_ok;
        q_cmd.push_index = idx_reg;
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load) begin
            rsp_valid_next = 1'b1;
        end else if (!rsp_stall) begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= dfla_pkg::ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept) begin
            op_reg    <= operation;
            idx_reg   <= free_index;
            owner_reg <= owner_id;
        end
        if (calc_load) begin
            status_calc_reg <= status_calc;
            alloc_ok_reg    <= alloc_ok;
            visible_reg     <= visible;
            slot_calc_reg   <= q_stat.head_index;
        end
        if (rsp_load) begin
            status_reg      <= status_calc_reg;
            slot_reg        <= alloc_ok_reg ? slot_calc_reg : '0;
            cpu_addr_reg    <= alloc_ok_reg ? cpu_sum : '0;
            gpu_addr_reg    <= alloc_ok_reg ? gpu_sum : '0;
            visible_out_reg <= visible_reg;
            used_reg        <= dfla_pkg::COUNT_W'(q_stat.alloc_total);
            avail_reg       <= dfla_pkg::COUNT_W'(q_stat.free_total);
        end
    end

    dfla_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .cap_eff (cap_eff),
        .cmd     (q_cmd),
        .stat    (q_stat)
    );

    // The head index is the multiplier input in CALC; the product is
    // registered and the additions happen in ADD.
    dfla_addr u_addr (
        .clk      (clk),
        .load     (calc_load),
        .slot     (q_stat.head_index),
        .stride   (stride_reg),
        .cpu_base (cpu_base_reg),
        .gpu_base (gpu_base_reg),
        .visible  (visible_reg),
        .cpu_sum  (cpu_sum),
        .gpu_sum  (gpu_sum)
    );

    assign rsp_valid       = rsp_valid_reg;
    assign status          = status_reg;
    assign slot_index      = slot_reg;
    assign cpu_address     = cpu_addr_reg;
    assign gpu_address     = gpu_addr_reg;
    assign shader_visible  = visible_out_reg;
    assign used_count      = used_reg;
    assign available_count = avail_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // The free count never exceeds the capacity in force.
    a_free_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.free_total <= cap_eff)
        else $error("free count exceeds capacity");

    // A response only appears after the add cycle of an item.
    a_rsp_from_add: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg == dfla_pkg::ST_ADD))
        else $error("response raised outside the add cycle");

    // An accepted item always starts with a memory read.
    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == dfla_pkg::ST_READ))
        else $error("accepted item did not start a read");

    // Failed requests carry no slot and no addresses.
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status != dfla_pkg::STATUS_OK))
            |-> (slot_index == '0) && (cpu_address == '0) && (gpu_address == '0))
        else $error("error response carries a slot or an address");

endmodule
